/* rtl/core/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, codes and helpers for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } char_beat_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } res_beat_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_LPAR
    } op_code_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_OP,
        CLS_RPAR,
        CLS_LETTER,
        CLS_BAD
    } char_class_t;

    typedef enum logic {
        TK_CHAR,
        TK_ASSIGN
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        char_class_t cls;
        op_code_t    op;
        logic [3:0]  digit;
        logic [4:0]  idx;
        logic        last;
    } token_t;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_BODY
    } line_pos_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_CHAR,
        BK_AFTER,
        BK_FINAL,
        BK_LTOP,
        BK_LCHK,
        BK_R1,
        BK_R2,
        BK_EXEC,
        BK_MUL,
        BK_MULFIN,
        BK_DIV,
        BK_DIVFIN,
        BK_PUSH,
        BK_RES,
        BK_OUT
    } bk_state_t;

    typedef enum logic [1:0] {
        LK_PROD,
        LK_PAREN,
        LK_ALL
    } loop_kind_t;

    localparam int VARIABLE_COUNT = 26;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_DIV_ZERO = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    function automatic token_t classify(input logic [7:0] c);
        token_t t;
        logic [7:0] off_d;
        logic [7:0] off_a;
        t       = '0;
        off_d   = c - CH_0;
        off_a   = c - CH_A;
        t.kind  = TK_CHAR;
        t.cls   = CLS_BAD;
        t.op    = OP_ADD;
        if (c >= CH_0 && c <= CH_9) begin
            t.cls   = CLS_DIGIT;
            t.digit = off_d[3:0];
        end else if (c >= CH_A && c <= CH_Z) begin
            t.cls = CLS_LETTER;
            t.idx = off_a[4:0];
        end else begin
            case (c)
                CH_PLUS:  begin t.cls = CLS_OP; t.op = OP_ADD;  end
                CH_MINUS: begin t.cls = CLS_OP; t.op = OP_SUB;  end
                CH_STAR:  begin t.cls = CLS_OP; t.op = OP_MUL;  end
                CH_SLASH: begin t.cls = CLS_OP; t.op = OP_DIV;  end
                CH_LPAR:  begin t.cls = CLS_OP; t.op = OP_LPAR; end
                CH_RPAR:  t.cls = CLS_RPAR;
                default:  t.cls = CLS_BAD;
            endcase
        end
        return t;
    endfunction

    function automatic logic [63:0] magnitude(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] sat_from_mag(input logic neg, input logic [63:0] hi,
                                                 input logic [63:0] lo);
        logic [63:0] r;
        if (!neg) begin
            r = (hi != 64'd0 || lo[63]) ? VAL_MAX : lo;
        end else begin
            r = (hi != 64'd0 || lo[63]) ? VAL_MIN : (~lo + 64'd1);
        end
        return r;
    endfunction

endpackage

/* rtl/core/iee_front.sv */
// ----------------------------------------------------------------------------
// iee_front
// Accepts character beats, tracks the line head and emits classified tokens.
// ----------------------------------------------------------------------------
module iee_front import iee_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_beat_t char_beat,
    output logic       tok_push,
    output token_t     tok,
    input  logic       q_full
);

    line_pos_t  pos_reg, pos_next;
    logic [7:0] held_reg, held_next;
    logic       pend_valid_reg, pend_valid_next;
    token_t     pend_reg, pend_next;
    token_t     cur_tok;
    token_t     held_tok;
    logic       accept;

    assign char_stall = q_full || pend_valid_reg;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        cur_tok       = classify(char_beat.char_code);
        cur_tok.last  = char_beat.line_end;
        held_tok      = classify(held_reg);
        held_tok.last = 1'b0;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (!pend_valid_reg && accept) begin
            unique case (pos_reg)
                POS_FIRST:  pos_next = char_beat.line_end ? POS_FIRST : POS_SECOND;
                POS_SECOND: pos_next = char_beat.line_end ? POS_FIRST : POS_BODY;
                POS_BODY:   pos_next = char_beat.line_end ? POS_FIRST : POS_BODY;
                default:    pos_next = POS_FIRST;
            endcase
        end
    end

    always_comb
    begin
        held_next       = held_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        tok_push        = 1'b0;
        tok             = cur_tok;
        if (pend_valid_reg) begin
            tok = pend_reg;
            if (!q_full) begin
                tok_push        = 1'b1;
                pend_valid_next = 1'b0;
            end
        end else if (accept) begin
            unique case (pos_reg)
                POS_FIRST:
                begin
                    if (char_beat.line_end) begin
                        tok_push = 1'b1;
                    end else begin
                        held_next = char_beat.char_code;
                    end
                end
                POS_SECOND:
                begin
                    tok_push = 1'b1;
                    if (char_beat.char_code == CH_EQ) begin
                        tok      = held_tok;
                        tok.kind = TK_ASSIGN;
                        tok.last = char_beat.line_end;
                    end else begin
                        tok             = held_tok;
                        pend_next       = cur_tok;
                        pend_valid_next = 1'b1;
                    end
                    if (char_beat.line_end) begin
                        held_next = 8'd0;
                    end
                end
                default:
                begin
                    tok_push = 1'b1;
                    if (char_beat.line_end) begin
                        held_next = 8'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= POS_FIRST;
            held_reg       <= 8'd0;
            pend_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* rtl/core/iee_queue.sv */
// ----------------------------------------------------------------------------
// iee_queue
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
module iee_queue import iee_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t din,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output token_t dout
);

    token_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign dout    = mem[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/iee_back.sv */
// ----------------------------------------------------------------------------
// iee_back
// Executes tokens against the operator and value stacks and forms results.
// ----------------------------------------------------------------------------
module iee_back import iee_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  token_t    q_tok,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_beat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    op_code_t    op_mem  [STACK_DEPTH];
    logic [63:0] val_mem [STACK_DEPTH];
    op_code_t    op_rd_reg;
    logic [63:0] val_rd_reg;
    logic [AW-1:0] op_raddr, val_raddr, op_waddr, val_waddr;
    logic        op_we, val_we;
    op_code_t    op_wdata;
    logic [63:0] val_wdata;

    bk_state_t   state_reg, state_next;
    loop_kind_t  lk_reg, lk_next;
    bk_state_t   ret_reg, ret_next;
    token_t      tok_reg, tok_next;
    logic [CW-1:0] ocnt_reg, ocnt_next, vcnt_reg, vcnt_next;
    logic [63:0] acc_reg, acc_next;
    logic        in_num_reg, in_num_next;
    logic        assign_reg, assign_next;
    logic        tgt_valid_reg, tgt_valid_next;
    logic [4:0]  tgt_idx_reg, tgt_idx_next;
    logic [1:0]  err_reg, err_next;
    op_code_t    op_cur_reg, op_cur_next;
    logic        flip_reg, flip_next;
    logic [63:0] a_reg, a_next, b_reg, b_next, res_reg, res_next;
    logic        neg_reg, neg_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;
    logic [2:0]  mstep_reg, mstep_next;
    logic [63:0] pp_reg, pp_next;
    logic [1:0]  pp_pos_reg, pp_pos_next;
    logic [127:0] prod_reg, prod_next, num_reg, num_next, quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic [63:0] var_reg [VARIABLE_COUNT];
    logic        var_we;
    logic [63:0] var_wdata;
    logic        out_valid_reg;
    res_beat_t   out_reg;
    logic        out_load;

    logic        do_reduce, out_free, vfull, ofull;
    logic        vpush, opush;
    logic [63:0] vpush_data;
    logic [1:0]  err_set;
    logic [67:0] digit_sum;
    logic [64:0] as65, bs65, sum65, rem_sh;
    logic        ge;
    logic [127:0] prod_sh;
    logic [31:0] x_part, y_part;
    logic [63:0] out_v;

    assign vfull     = vcnt_reg >= CW'(STACK_DEPTH);
    assign ofull     = ocnt_reg >= CW'(STACK_DEPTH);
    assign out_free  = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;
    assign out_v     = (vcnt_reg != '0) ? val_rd_reg : 64'd0;

    always_comb
    begin
        if (lk_reg == LK_PROD) begin
            do_reduce = (op_rd_reg == OP_MUL) || (op_rd_reg == OP_DIV);
        end else begin
            do_reduce = op_rd_reg != OP_LPAR;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:     state_next = q_valid ? BK_DISPATCH : BK_IDLE;
            BK_DISPATCH:
            begin
                if (tok_reg.kind == TK_ASSIGN) begin
                    state_next = BK_AFTER;
                end else if (in_num_reg && tok_reg.cls != CLS_DIGIT) begin
                    state_next = BK_LTOP;
                end else begin
                    state_next = BK_CHAR;
                end
            end
            BK_CHAR:
            begin
                if (tok_reg.cls == CLS_RPAR || tok_reg.cls == CLS_LETTER) begin
                    state_next = BK_LTOP;
                end else begin
                    state_next = BK_AFTER;
                end
            end
            BK_AFTER:
            begin
                if (!tok_reg.last) begin
                    state_next = BK_IDLE;
                end else begin
                    state_next = in_num_reg ? BK_LTOP : BK_FINAL;
                end
            end
            BK_FINAL:    state_next = BK_LTOP;
            BK_LTOP:
            begin
                if (ocnt_reg != '0) begin
                    state_next = BK_LCHK;
                end else if (lk_reg == LK_PROD) begin
                    state_next = ret_reg;
                end else if (lk_reg == LK_ALL) begin
                    state_next = BK_RES;
                end else begin
                    state_next = BK_LTOP;
                end
            end
            BK_LCHK:
            begin
                if (do_reduce) begin
                    state_next = BK_R1;
                end else if (lk_reg == LK_PROD) begin
                    state_next = ret_reg;
                end else begin
                    state_next = BK_LTOP;
                end
            end
            BK_R1:       state_next = BK_R2;
            BK_R2:       state_next = BK_EXEC;
            BK_EXEC:
            begin
                if (op_cur_reg == OP_MUL) begin
                    state_next = BK_MUL;
                end else if (op_cur_reg == OP_DIV) begin
                    state_next = (b_reg == 64'd0) ? BK_PUSH : BK_DIV;
                end else begin
                    state_next = BK_PUSH;
                end
            end
            BK_MUL:      state_next = (mstep_reg == 3'd4) ? BK_MULFIN : BK_MUL;
            BK_MULFIN:   state_next = BK_PUSH;
            BK_DIV:      state_next = (dcnt_reg == 7'd127) ? BK_DIVFIN : BK_DIV;
            BK_DIVFIN:   state_next = BK_PUSH;
            BK_PUSH:     state_next = BK_LTOP;
            BK_RES:      state_next = BK_OUT;
            BK_OUT:      state_next = (assign_reg || out_free) ? BK_IDLE : BK_OUT;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        lk_next        = lk_reg;
        ret_next       = ret_reg;
        tok_next       = tok_reg;
        ocnt_next      = ocnt_reg;
        vcnt_next      = vcnt_reg;
        acc_next       = acc_reg;
        in_num_next    = in_num_reg;
        assign_next    = assign_reg;
        tgt_valid_next = tgt_valid_reg;
        tgt_idx_next   = tgt_idx_reg;
        err_next       = err_reg;
        op_cur_next    = op_cur_reg;
        flip_next      = flip_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        mstep_next     = mstep_reg;
        pp_next        = pp_reg;
        pp_pos_next    = pp_pos_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        op_raddr       = AW'(ocnt_reg - CW'(1));
        val_raddr      = '0;
        op_we          = 1'b0;
        op_waddr       = ocnt_reg[AW-1:0];
        op_wdata       = tok_reg.op;
        val_we         = 1'b0;
        val_waddr      = vcnt_reg[AW-1:0];
        vpush          = 1'b0;
        vpush_data     = res_reg;
        val_wdata      = vpush_data;
        opush          = 1'b0;
        err_set        = ST_OK;
        var_we         = 1'b0;
        var_wdata      = out_v;
        out_load       = 1'b0;

        digit_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                  + (68'(tok_reg.digit) << FRAC_BITS);
        as65  = {a_reg[63], a_reg};
        bs65  = {b_reg[63], b_reg};
        sum65 = ((op_cur_reg == OP_ADD) != flip_reg) ? (as65 + bs65) : (as65 - bs65);
        rem_sh  = {rem_reg, num_reg[127]};
        ge      = rem_sh >= {1'b0, y_reg};
        prod_sh = prod_reg >> FRAC_BITS;
        x_part  = mstep_reg[1] ? x_reg[63:32] : x_reg[31:0];
        y_part  = mstep_reg[0] ? y_reg[63:32] : y_reg[31:0];

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid) begin
                    tok_next = q_tok;
                end
            end
            BK_DISPATCH:
            begin
                if (tok_reg.kind == TK_ASSIGN) begin
                    assign_next    = 1'b1;
                    tgt_valid_next = tok_reg.cls == CLS_LETTER;
                    tgt_idx_next   = tok_reg.idx;
                end else if (in_num_reg && tok_reg.cls != CLS_DIGIT) begin
                    vpush       = 1'b1;
                    vpush_data  = acc_reg;
                    acc_next    = 64'd0;
                    in_num_next = 1'b0;
                    lk_next     = LK_PROD;
                    ret_next    = BK_CHAR;
                end
            end
            BK_CHAR:
            begin
                case (tok_reg.cls)
                    CLS_DIGIT:
                    begin
                        acc_next    = (digit_sum > 68'(VAL_MAX)) ? VAL_MAX : digit_sum[63:0];
                        in_num_next = 1'b1;
                    end
                    CLS_OP:     opush = 1'b1;
                    CLS_RPAR:
                    begin
                        lk_next  = LK_PAREN;
                        ret_next = BK_AFTER;
                    end
                    CLS_LETTER:
                    begin
                        vpush      = 1'b1;
                        vpush_data = var_reg[tok_reg.idx];
                        lk_next    = LK_PROD;
                        ret_next   = BK_AFTER;
                    end
                    default:    err_set = ST_BAD_CHAR;
                endcase
            end
            BK_AFTER:
            begin
                if (tok_reg.last && in_num_reg) begin
                    vpush       = 1'b1;
                    vpush_data  = acc_reg;
                    acc_next    = 64'd0;
                    in_num_next = 1'b0;
                    lk_next     = LK_PROD;
                    ret_next    = BK_FINAL;
                end
            end
            BK_FINAL:    lk_next = LK_ALL;
            BK_LTOP:
            begin
                if (ocnt_reg == '0 && lk_reg == LK_PAREN) begin
                    lk_next = LK_PROD;
                end
            end
            BK_LCHK:
            begin
                if (do_reduce) begin
                    op_cur_next = op_rd_reg;
                    ocnt_next   = ocnt_reg - CW'(1);
                    op_raddr    = AW'(ocnt_reg - CW'(2));
                    val_raddr   = AW'(vcnt_reg - CW'(1));
                end else if (lk_reg != LK_PROD) begin
                    ocnt_next = ocnt_reg - CW'(1);
                    if (lk_reg == LK_PAREN) begin
                        lk_next = LK_PROD;
                    end
                end
            end
            BK_R1:
            begin
                flip_next = (ocnt_reg != '0) && (op_rd_reg == OP_SUB);
                if (vcnt_reg != '0) begin
                    b_next    = val_rd_reg;
                    vcnt_next = vcnt_reg - CW'(1);
                    val_raddr = AW'(vcnt_reg - CW'(2));
                end else begin
                    b_next = 64'd0;
                end
            end
            BK_R2:
            begin
                if (vcnt_reg != '0) begin
                    a_next    = val_rd_reg;
                    vcnt_next = vcnt_reg - CW'(1);
                end else begin
                    a_next = 64'd0;
                end
            end
            BK_EXEC:
            begin
                neg_next   = a_reg[63] ^ b_reg[63];
                x_next     = magnitude(a_reg);
                y_next     = magnitude(b_reg);
                mstep_next = 3'd0;
                prod_next  = '0;
                num_next   = {64'd0, magnitude(a_reg)} << FRAC_BITS;
                quo_next   = '0;
                rem_next   = 64'd0;
                dcnt_next  = 7'd0;
                if (op_cur_reg == OP_DIV) begin
                    if (b_reg == 64'd0) begin
                        err_set  = ST_DIV_ZERO;
                        res_next = a_reg[63] ? VAL_MIN : VAL_MAX;
                    end
                end else if (op_cur_reg != OP_MUL) begin
                    if (sum65[64] != sum65[63]) begin
                        res_next = sum65[64] ? VAL_MIN : VAL_MAX;
                    end else begin
                        res_next = sum65[63:0];
                    end
                end
            end
            BK_MUL:
            begin
                if (mstep_reg != 3'd4) begin
                    pp_next     = {32'd0, x_part} * {32'd0, y_part};
                    pp_pos_next = {1'b0, mstep_reg[1]} + {1'b0, mstep_reg[0]};
                end
                if (mstep_reg != 3'd0) begin
                    prod_next = prod_reg + ({64'd0, pp_reg} << {pp_pos_reg, 5'b00000});
                end
                mstep_next = mstep_reg + 3'd1;
            end
            BK_MULFIN:   res_next = sat_from_mag(neg_reg, prod_sh[127:64], prod_sh[63:0]);
            BK_DIV:
            begin
                rem_next  = ge ? 64'(rem_sh - {1'b0, y_reg}) : rem_sh[63:0];
                quo_next  = {quo_reg[126:0], ge};
                num_next  = {num_reg[126:0], 1'b0};
                dcnt_next = dcnt_reg + 7'd1;
            end
            BK_DIVFIN:   res_next = sat_from_mag(neg_reg, quo_reg[127:64], quo_reg[63:0]);
            BK_PUSH:     vpush = 1'b1;
            BK_OUT:
            begin
                if (assign_reg || out_free) begin
                    if (assign_reg) begin
                        var_we = tgt_valid_reg;
                    end else begin
                        out_load = 1'b1;
                    end
                    ocnt_next      = '0;
                    vcnt_next      = '0;
                    acc_next       = 64'd0;
                    in_num_next    = 1'b0;
                    assign_next    = 1'b0;
                    tgt_valid_next = 1'b0;
                    err_next       = ST_OK;
                end
            end
            default:
            begin
            end
        endcase

        if (vpush) begin
            if (vfull) begin
                err_set = ST_OVERFLOW;
            end else begin
                val_we    = 1'b1;
                val_wdata = vpush_data;
                vcnt_next = vcnt_reg + CW'(1);
            end
        end
        if (opush) begin
            if (ofull) begin
                err_set = ST_OVERFLOW;
            end else begin
                op_we     = 1'b1;
                ocnt_next = ocnt_reg + CW'(1);
            end
        end
        if (err_set != ST_OK && err_reg == ST_OK) begin
            err_next = err_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_we) begin
            op_mem[op_waddr] <= op_wdata;
        end
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        op_rd_reg  <= op_mem[op_raddr];
        val_rd_reg <= val_mem[val_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            lk_reg        <= LK_PROD;
            ret_reg       <= BK_AFTER;
            ocnt_reg      <= '0;
            vcnt_reg      <= '0;
            acc_reg       <= 64'd0;
            in_num_reg    <= 1'b0;
            assign_reg    <= 1'b0;
            tgt_valid_reg <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VARIABLE_COUNT; i++) begin
                var_reg[i] <= 64'd0;
            end
        end else begin
            state_reg     <= state_next;
            lk_reg        <= lk_next;
            ret_reg       <= ret_next;
            ocnt_reg      <= ocnt_next;
            vcnt_reg      <= vcnt_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            assign_reg    <= assign_next;
            tgt_valid_reg <= tgt_valid_next;
            err_reg       <= err_next;
            if (var_we) begin
                var_reg[tgt_idx_reg] <= var_wdata;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (!res_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg     <= tok_next;
        tgt_idx_reg <= tgt_idx_next;
        op_cur_reg  <= op_cur_next;
        flip_reg    <= flip_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        neg_reg     <= neg_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        mstep_reg   <= mstep_next;
        pp_reg      <= pp_next;
        pp_pos_reg  <= pp_pos_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        if (out_load) begin
            out_reg.value  <= $signed(out_v);
            out_reg.status <= err_reg;
        end
    end

endmodule

/* rtl/core/infix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Evaluates infix arithmetic lines in signed Q47.16, one character per beat.
// ----------------------------------------------------------------------------
// Characters enter the front at one beat per cycle while the four-entry token
// queue has room; the second character of a line that is not '=' stalls the
// input while its token waits behind the held first character. The back
// executes one token at a time, with a stack walk at each reduction for +, -,
// * and /, and a division yields one quotient bit per cycle over 128 bits. A
// line end also runs its remaining reductions. The stacks are simple dual-port
// memories with registered reads.
module infix_expression_evaluator_core import iee_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_beat_t char_beat,
    output logic       res_valid,
    input  logic       res_stall,
    output res_beat_t  res_beat
);

    logic   tok_push;
    token_t tok;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    token_t q_tok;

    iee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .tok_push   (tok_push),
        .tok        (tok),
        .q_full     (q_full)
    );

    iee_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .din   (tok),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_tok)
    );

    iee_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_tok     (q_tok),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

/* tb/sv/iee_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iee_checker
// Watches both channels of the infix evaluator, predicts each line's value
// and status from the accepted characters, and compares them with results.
// ----------------------------------------------------------------------------
module iee_checker import iee_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_stall,
    input  char_beat_t char_beat,
    input  logic       res_valid,
    input  logic       res_stall,
    input  res_beat_t  res_beat,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    localparam logic signed [63:0] POS_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] NEG_LIM = 64'sh8000_0000_0000_0000;

    op_code_t          ops [STACK_DEPTH];
    int                op_cnt;
    logic signed [63:0] vals [STACK_DEPTH];
    int                val_cnt;
    logic signed [63:0] vars [VARIABLE_COUNT];
    logic signed [63:0] acc;
    logic              in_num;
    logic [7:0]        held;
    line_pos_t         pos;
    logic              assign_line;
    logic [1:0]        err;
    res_beat_t         line_results [$];

    function automatic void flag(logic [1:0] code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [64:0] s);
        if (s > 65'(POS_LIM)) return POS_LIM;
        if (s < 65'(NEG_LIM)) return NEG_LIM;
        return s[63:0];
    endfunction

    function automatic logic [63:0] absval(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_sat(logic neg, logic [127:0] m);
        if (!neg) return (m > 128'(POS_LIM)) ? POS_LIM : m[63:0];
        return (m >= 128'h8000_0000_0000_0000) ? NEG_LIM : -$signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] fx_product(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        logic [127:0] p;
        p = ({64'd0, absval(a)} * {64'd0, absval(b)}) >> FRAC_BITS;
        return signed_sat((a < 0) != (b < 0), p);
    endfunction

    function automatic logic signed [63:0] fx_quotient(logic signed [63:0] a,
                                                       logic signed [63:0] b);
        logic [127:0] q;
        if (b == 0) begin
            flag(ST_DIV_ZERO);
            return a < 0 ? NEG_LIM : POS_LIM;
        end
        q = ({64'd0, absval(a)} << FRAC_BITS) / {64'd0, absval(b)};
        return signed_sat((a < 0) != (b < 0), q);
    endfunction

    function automatic void push_val(logic signed [63:0] v);
        if (val_cnt >= STACK_DEPTH) begin
            flag(ST_OVERFLOW);
            return;
        end
        vals[val_cnt] = v;
        val_cnt++;
    endfunction

    function automatic void push_op(op_code_t op);
        if (op_cnt >= STACK_DEPTH) begin
            flag(ST_OVERFLOW);
            return;
        end
        ops[op_cnt] = op;
        op_cnt++;
    endfunction

    function automatic logic signed [63:0] pop_val();
        if (val_cnt == 0) return 0;
        val_cnt--;
        return vals[val_cnt];
    endfunction

    function automatic void apply_top();
        op_code_t op;
        logic flip;
        logic signed [63:0] a, b, r;
        op_cnt--;
        op = ops[op_cnt];
        flip = op_cnt > 0 && ops[op_cnt-1] == OP_SUB;
        b = pop_val();
        a = pop_val();
        case (op)
            OP_ADD:  r = flip ? clamp(65'(a) - 65'(b)) : clamp(65'(a) + 65'(b));
            OP_SUB:  r = flip ? clamp(65'(a) + 65'(b)) : clamp(65'(a) - 65'(b));
            OP_MUL:  r = fx_product(a, b);
            default: r = fx_quotient(a, b);
        endcase
        push_val(r);
    endfunction

    function automatic void fold_products();
        while (op_cnt > 0 && (ops[op_cnt-1] == OP_MUL || ops[op_cnt-1] == OP_DIV))
            apply_top();
    endfunction

    function automatic void close_number();
        if (!in_num) return;
        push_val(acc);
        acc = 0;
        in_num = 0;
        fold_products();
    endfunction

    function automatic void eat_char(logic [7:0] c);
        logic signed [63:0] add;
        logic is_digit;
        is_digit = c >= CH_0 && c <= CH_9;
        if (in_num && !is_digit) close_number();
        if (is_digit) begin
            add = 64'(c - CH_0) << FRAC_BITS;
            if (acc > (POS_LIM - add) / 10) acc = POS_LIM;
            else acc = acc * 10 + add;
            in_num = 1;
        end else if (c == CH_PLUS)  push_op(OP_ADD);
        else if (c == CH_MINUS) push_op(OP_SUB);
        else if (c == CH_STAR)  push_op(OP_MUL);
        else if (c == CH_SLASH) push_op(OP_DIV);
        else if (c == CH_LPAR)  push_op(OP_LPAR);
        else if (c == CH_RPAR) begin
            while (op_cnt > 0 && ops[op_cnt-1] != OP_LPAR) apply_top();
            if (op_cnt > 0) op_cnt--;
            fold_products();
        end else if (c >= CH_A && c <= CH_Z) begin
            push_val(vars[c - CH_A]);
            fold_products();
        end else flag(ST_BAD_CHAR);
    endfunction

    function automatic void clear_line();
        op_cnt = 0;
        val_cnt = 0;
        acc = 0;
        in_num = 0;
        held = 0;
        pos = POS_FIRST;
        assign_line = 0;
        err = ST_OK;
    endfunction

    function automatic void end_line();
        logic signed [63:0] v;
        res_beat_t r;
        close_number();
        while (op_cnt > 0) begin
            if (ops[op_cnt-1] == OP_LPAR) op_cnt--;
            else apply_top();
        end
        v = val_cnt > 0 ? vals[0] : 64'sd0;
        if (assign_line) begin
            if (held >= CH_A && held <= CH_Z) vars[held - CH_A] = v;
        end else begin
            r.value = v;
            r.status = err;
            line_results.push_back(r);
        end
        clear_line();
    endfunction

    function automatic void take_char(logic [7:0] c, logic last);
        case (pos)
            POS_FIRST: begin
                if (last) eat_char(c);
                else begin
                    held = c;
                    pos = POS_SECOND;
                end
            end
            POS_SECOND: begin
                if (c == CH_EQ) assign_line = 1;
                else begin
                    eat_char(held);
                    eat_char(c);
                end
                pos = POS_BODY;
            end
            default: eat_char(c);
        endcase
        if (last) end_line();
    endfunction

    initial begin
        fail_count = 0;
        checked = 0;
        pending = 0;
        for (int i = 0; i < VARIABLE_COUNT; i++) vars[i] = 0;
        clear_line();
    end

    always @(posedge clk) begin
        res_beat_t want;
        if (rst_n) begin
            if (char_valid && !char_stall)
                take_char(char_beat.char_code, char_beat.line_end);
            if (res_valid && !res_stall) begin
                checked++;
                if (line_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: value=%0d status=%0d",
                                 res_beat.value, res_beat.status);
                end else begin
                    want = line_results.pop_front();
                    if (want.value !== res_beat.value || want.status !== res_beat.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                                     want.value, want.status, res_beat.value, res_beat.status);
                    end
                end
            end
            pending = line_results.size();
        end
    end

endmodule

/* tb/sv/tb_infix_expression_evaluator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator_core
// Drives text lines into the evaluator (directed cases, then random
// expressions, assignments and noise) under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator_core;
    import iee_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    char_beat_t char_beat;
    logic       res_valid;
    logic       res_stall;
    res_beat_t  res_beat;
    int         fail_count;
    int         pending;
    int         checked;
    int         idle_pct;
    int         stall_pct;
    int         chars_sent;
    int         quiet_cycles;
    byte        line_q [$];

    infix_expression_evaluator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_beat   (res_beat)
    );

    iee_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_beat   (res_beat),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(negedge clk) res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        if ((char_valid && !char_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input byte c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_beat.char_code <= c;
        char_beat.line_end <= last;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_beat(line_q[i], i == line_q.size() - 1);
        char_valid <= 1'b0;
        line_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line();
    endtask

    task automatic add_number();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 3);
        repeat (n) line_q.push_back(byte'(CH_0 + $urandom_range(9)));
    endtask

    task automatic add_expr(input int depth);
        int terms;
        int r;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                case ($urandom_range(3))
                    0: line_q.push_back(CH_PLUS);
                    1: line_q.push_back(CH_MINUS);
                    2: line_q.push_back(CH_STAR);
                    default: line_q.push_back(CH_SLASH);
                endcase
            end
            if ($urandom_range(99) < 15) line_q.push_back(CH_MINUS);
            r = $urandom_range(9);
            if (r < 5) add_number();
            else if (r < 8) line_q.push_back(byte'(CH_A + $urandom_range(25)));
            else if (depth < 3) begin
                line_q.push_back(CH_LPAR);
                add_expr(depth + 1);
                if ($urandom_range(19) != 0) line_q.push_back(CH_RPAR);
            end else add_number();
        end
    endtask

    task automatic random_line();
        int r;
        r = $urandom_range(99);
        if (r < 2) begin
            repeat ($urandom_range(64, 70)) line_q.push_back(CH_LPAR);
            add_expr(0);
        end else if (r < 60) begin
            add_expr(0);
        end else if (r < 82) begin
            line_q.push_back(byte'(CH_A + $urandom_range(25)));
            line_q.push_back(CH_EQ);
            if ($urandom_range(9) != 0) add_expr(0);
        end else if (r < 90) begin
            add_expr(0);
            line_q.insert($urandom_range(line_q.size()), byte'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 6)) line_q.push_back(byte'($urandom_range(255)));
        end
        send_line();
    endtask

    initial begin
        rst_n = 1'b0;
        char_valid = 1'b0;
        char_beat = '0;
        res_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        chars_sent = 0;
        quiet_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text("a=3");
        send_text("2*a/4");
        send_text("9-3-2");
        send_text("-5");
        send_text("8/0");
        send_text("(1#");
        send_text(")");
        send_text("1=");
        line_q.push_back(8'hFF);
        send_line();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            while (chars_sent < 25 + 275 * (ph + 1)) random_line();
        end

        while (pending != 0) @(negedge clk);
        repeat (3000) @(negedge clk);
        $display("Sent %0d characters of directed and random lines under four idle/stall mixes;",
                 chars_sent);
        $display("%0d result beats compared.", checked);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/iee_pkg.sv
rtl/core/iee_front.sv
rtl/core/iee_queue.sv
rtl/core/iee_back.sv
rtl/core/infix_expression_evaluator_core.sv
tb/sv/iee_checker.sv
tb/sv/tb_infix_expression_evaluator_core.sv
